>>> design/tagged_stream_byte_order_fixer_defines.svh
// Assertion macros for the byte-order fixer
`ifndef TAGGED_STREAM_BYTE_ORDER_FIXER_DEFINES_SVH
`define TAGGED_STREAM_BYTE_ORDER_FIXER_DEFINES_SVH

// Same-cycle implication
`define TSBOF_ASSERT_NOW(label, clk, rst, cond, conseq, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
      else $error(msg);

// Next-cycle implication
`define TSBOF_ASSERT_NEXT(label, clk, rst, cond, conseq, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
      else $error(msg);

`endif

>>> design/tsbof_pkg.sv
package tsbof_pkg;

   localparam int MAX_WORD_BYTES = 8;
   localparam int COUNT_W        = $clog2(MAX_WORD_BYTES + 1);
   localparam int HELD_W         = $clog2(MAX_WORD_BYTES);
   localparam int SKIP_W         = 31;
   localparam int QUEUE_DEPTH    = 4;
   localparam int QPTR_W         = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);

   localparam logic [COUNT_W-1:0] WORD_LEN_NONE  = COUNT_W'(0);
   localparam logic [COUNT_W-1:0] WORD_LEN_BYTE  = COUNT_W'(1);
   localparam logic [COUNT_W-1:0] WORD_LEN_SHORT = COUNT_W'(4);
   localparam logic [COUNT_W-1:0] WORD_LEN_LONG  = COUNT_W'(8);

   localparam logic [7:0] TAG_INT32     = 8'd0;
   localparam logic [7:0] TAG_UINT32    = 8'd1;
   localparam logic [7:0] TAG_DOUBLE    = 8'd4;
   localparam logic [7:0] TAG_FLOAT     = 8'd5;
   localparam logic [7:0] TAG_STRING    = 8'd6;
   localparam logic [7:0] TAG_INT64     = 8'd7;
   localparam logic [7:0] TAG_UINT64    = 8'd8;
   localparam logic [7:0] TAG_SUBSTREAM = 8'd9;

   localparam logic CSR_NATIVE_ORDER_MARK = 1'b0;
   localparam logic CSR_NATIVE_BIG_ENDIAN = 1'b1;

   typedef struct packed {
      logic [7:0] native_order_mark;
      logic       native_big_endian;
   } csr_type;

   // One group of output bytes; data[0] leaves first
   typedef struct packed {
      logic [MAX_WORD_BYTES-1:0][7:0] data;
      logic [COUNT_W-1:0]             count;
      logic                           last;
      logic                           trunc;
   } word_cmd_type;

endpackage

>>> design/tsbof_front.sv
module tsbof_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  logic [7:0]            req_byte_in,
   input  logic                  req_end_of_message,
   input  tsbof_pkg::csr_type    csr,
   output logic                  push,
   output tsbof_pkg::word_cmd_type push_cmd
);
   import tsbof_pkg::*;

   typedef enum logic [1:0] {PH_MARK, PH_TAG, PH_WORD, PH_SKIP} phase_type;

   phase_type          phase_ff, phase_in;
   logic               swap_ff, swap_in;
   logic [HELD_W-1:0]  held_ff, held_in;
   logic [COUNT_W-1:0] word_len_ff, word_len_in;
   logic               len_follows_ff, len_follows_in;
   logic [SKIP_W-1:0]  skip_ff, skip_in;
   logic [MAX_WORD_BYTES-1:0][7:0] word_buf_ff;

   logic [MAX_WORD_BYTES-1:0][7:0] nb;
   logic [MAX_WORD_BYTES-1:0][7:0] rev;
   logic [COUNT_W-1:0] held_next;
   logic               finish;
   logic [31:0]        len_word;
   logic [SKIP_W-1:0]  skip_val;
   logic               accept;
   logic               buf_we;

   assign accept    = req_valid && !req_stall;
   assign held_next = COUNT_W'(held_ff) + COUNT_W'(1);
   assign finish    = held_next >= word_len_ff;

   always_comb begin
      nb = word_buf_ff;
      nb[held_ff] = req_byte_in;
      rev = '0;
      case (word_len_ff)
         WORD_LEN_LONG: begin
            for (int i = 0; i < MAX_WORD_BYTES; i++) rev[i] = nb[MAX_WORD_BYTES-1-i];
         end
         WORD_LEN_SHORT: begin
            for (int i = 0; i < 4; i++) rev[i] = nb[3-i];
         end
         default: begin
            rev[0] = nb[0];
         end
      endcase
      if (csr.native_big_endian) len_word = {nb[3], nb[2], nb[1], nb[0]};
      else len_word = {nb[0], nb[1], nb[2], nb[3]};
      skip_val = len_word[31] ? '0 : len_word[SKIP_W-1:0];
   end

   always_comb begin
      phase_in       = phase_ff;
      swap_in        = swap_ff;
      held_in        = held_ff;
      word_len_in    = word_len_ff;
      len_follows_in = len_follows_ff;
      skip_in        = skip_ff;
      buf_we         = 1'b0;
      push           = 1'b0;
      push_cmd       = '0;
      push_cmd.data[0] = req_byte_in;
      push_cmd.count   = WORD_LEN_BYTE;
      push_cmd.last    = req_end_of_message;
      if (accept) begin
         if (phase_ff == PH_MARK) begin
            swap_in        = req_byte_in != csr.native_order_mark;
            phase_in       = PH_TAG;
            held_in        = '0;
            len_follows_in = 1'b0;
            skip_in        = '0;
         end else if (!swap_ff) begin
            push = 1'b1;
         end else begin
            unique case (phase_ff)
               PH_TAG: begin
                  push           = 1'b1;
                  held_in        = '0;
                  phase_in       = PH_WORD;
                  len_follows_in = 1'b0;
                  unique case (req_byte_in) inside
                     TAG_INT32, TAG_UINT32, TAG_FLOAT: word_len_in = WORD_LEN_SHORT;
                     TAG_DOUBLE, TAG_INT64, TAG_UINT64: word_len_in = WORD_LEN_LONG;
                     TAG_STRING, TAG_SUBSTREAM: begin
                        word_len_in    = WORD_LEN_SHORT;
                        len_follows_in = 1'b1;
                     end
                     default: word_len_in = WORD_LEN_BYTE;
                  endcase
               end
               PH_WORD: begin
                  buf_we = 1'b1;
                  if (finish) begin
                     push           = 1'b1;
                     push_cmd.data  = rev;
                     push_cmd.count = word_len_ff;
                     held_in        = '0;
                     phase_in       = PH_TAG;
                     len_follows_in = 1'b0;
                     if (len_follows_ff && word_len_ff == WORD_LEN_SHORT) begin
                        skip_in = skip_val;
                        if (skip_val != '0) phase_in = PH_SKIP;
                     end
                  end else begin
                     held_in = held_next[HELD_W-1:0];
                     if (req_end_of_message) begin
                        push           = 1'b1;
                        push_cmd.data  = nb;
                        push_cmd.count = held_next;
                        push_cmd.trunc = 1'b1;
                     end
                  end
               end
               PH_SKIP: begin
                  push    = 1'b1;
                  skip_in = skip_ff - SKIP_W'(1);
                  if (skip_in == '0) phase_in = PH_TAG;
               end
               default: begin
                  phase_in = PH_TAG;
               end
            endcase
         end
         if (req_end_of_message) begin
            phase_in       = PH_MARK;
            swap_in        = 1'b0;
            held_in        = '0;
            word_len_in    = WORD_LEN_NONE;
            len_follows_in = 1'b0;
            skip_in        = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_MARK;
         swap_ff        <= 1'b0;
         held_ff        <= '0;
         word_len_ff    <= WORD_LEN_NONE;
         len_follows_ff <= 1'b0;
         skip_ff        <= '0;
      end else begin
         phase_ff       <= phase_in;
         swap_ff        <= swap_in;
         held_ff        <= held_in;
         word_len_ff    <= word_len_in;
         len_follows_ff <= len_follows_in;
         skip_ff        <= skip_in;
      end
      if (buf_we) word_buf_ff[held_ff] <= req_byte_in;
   end

endmodule

>>> design/tsbof_queue.sv
module tsbof_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  tsbof_pkg::word_cmd_type push_cmd,
   output logic                    full,
   input  logic                    pop,
   output tsbof_pkg::word_cmd_type pop_cmd,
   output logic                    empty
);
   import tsbof_pkg::*;

   word_cmd_type       slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0]  count_ff;
   logic               do_push, do_pop;

   assign full    = count_ff == QCNT_W'(QUEUE_DEPTH);
   assign empty   = count_ff == '0;
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign pop_cmd = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
         end
         if (do_push && !do_pop) count_ff <= count_ff + QCNT_W'(1);
         else if (do_pop && !do_push) count_ff <= count_ff - QCNT_W'(1);
      end
      if (do_push) slot_ff[wr_ptr_ff] <= push_cmd;
   end

endmodule

>>> design/tsbof_back.sv
module tsbof_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    q_empty,
   input  tsbof_pkg::word_cmd_type q_cmd,
   output logic                    q_pop,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [7:0]              rsp_byte_out,
   output logic                    rsp_last_of_message,
   output logic                    rsp_truncated
);
   import tsbof_pkg::*;

   word_cmd_type       cur_ff;
   logic               cur_valid_ff;
   logic [HELD_W-1:0]  cur_idx_ff;
   logic               out_valid_ff;
   logic [7:0]         out_byte_ff;
   logic               out_last_ff;
   logic               out_trunc_ff;
   logic               load_out;
   logic               final_beat;
   logic               cur_done;

   assign load_out   = cur_valid_ff && (!out_valid_ff || !rsp_stall);
   assign final_beat = (COUNT_W'(cur_idx_ff) + COUNT_W'(1)) == cur_ff.count;
   assign cur_done   = load_out && final_beat;
   assign q_pop      = !q_empty && (!cur_valid_ff || cur_done);

   assign rsp_valid           = out_valid_ff;
   assign rsp_byte_out        = out_byte_ff;
   assign rsp_last_of_message = out_last_ff;
   assign rsp_truncated       = out_trunc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         cur_idx_ff   <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (q_pop) begin
            cur_valid_ff <= 1'b1;
            cur_idx_ff   <= '0;
         end else if (cur_done) begin
            cur_valid_ff <= 1'b0;
         end else if (load_out) begin
            cur_idx_ff <= cur_idx_ff + HELD_W'(1);
         end
         if (load_out) out_valid_ff <= 1'b1;
         else if (!rsp_stall) out_valid_ff <= 1'b0;
      end
      if (q_pop) cur_ff <= q_cmd;
      if (load_out) begin
         out_byte_ff  <= cur_ff.data[cur_idx_ff];
         out_last_ff  <= cur_ff.last && final_beat;
         out_trunc_ff <= cur_ff.trunc;
      end
   end

endmodule

>>> design/tagged_stream_byte_order_fixer.sv
// channel | ports                                   | beat
// req     | req_valid req_stall req_byte_in         | one raw message byte
//         | req_end_of_message                      |
// rsp     | rsp_valid rsp_stall rsp_byte_out        | one corrected byte
//         | rsp_last_of_message rsp_truncated       |
// csr     | csr_write_enable csr_index csr_write_data | one register write
//
// Takes one byte per cycle while req_stall is low; the parser pushes groups of up to 8
// bytes into a 4-entry queue; the serialiser sends one byte per cycle from it while
// rsp_stall is low; bytes reach rsp via queue slot, cur_ff and the output register.
// req_stall is high only while the queue is full; rsp_stall holds the output register.
// Synchronous reset clears parser state, queue and output valid; no clearing pass.
`include "tagged_stream_byte_order_fixer_defines.svh"

module tagged_stream_byte_order_fixer (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_byte_in,
   input  logic       req_end_of_message,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_byte_out,
   output logic       rsp_last_of_message,
   output logic       rsp_truncated,
   input  logic       csr_write_enable,
   input  logic       csr_index,
   input  logic [7:0] csr_write_data
);
   import tsbof_pkg::*;

   csr_type      csr_ff;
   logic         q_push, q_pop, q_full, q_empty;
   word_cmd_type q_push_cmd, q_pop_cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_NATIVE_ORDER_MARK: csr_ff.native_order_mark <= csr_write_data;
            CSR_NATIVE_BIG_ENDIAN: csr_ff.native_big_endian <= csr_write_data[0];
            default: csr_ff <= csr_ff;
         endcase
      end
   end

   assign req_stall = q_full;

   tsbof_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (q_full),
      .req_byte_in        (req_byte_in),
      .req_end_of_message (req_end_of_message),
      .csr                (csr_ff),
      .push               (q_push),
      .push_cmd           (q_push_cmd)
   );

   tsbof_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (q_push_cmd),
      .full     (q_full),
      .pop      (q_pop),
      .pop_cmd  (q_pop_cmd),
      .empty    (q_empty)
   );

   tsbof_back u_back (
      .clock               (clock),
      .reset               (reset),
      .q_empty             (q_empty),
      .q_cmd               (q_pop_cmd),
      .q_pop               (q_pop),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_byte_out        (rsp_byte_out),
      .rsp_last_of_message (rsp_last_of_message),
      .rsp_truncated       (rsp_truncated)
   );

   `TSBOF_ASSERT_NOW(a_no_push_when_full, clock, reset, q_push, !q_full, "push into full queue")
   `TSBOF_ASSERT_NOW(a_no_pop_when_empty, clock, reset, q_pop, !q_empty, "pop from empty queue")
   `TSBOF_ASSERT_NEXT(a_trunc_run, clock, reset, rsp_valid && !rsp_stall && rsp_truncated && !rsp_last_of_message, rsp_valid && rsp_truncated, "truncated flush broken")

endmodule
